// ===== rtl/assert_macros.svh =====
// Assertion macros used by the gap finder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/igf_pkg.sv =====
// Types, constants and helper functions of the interval gap finder.
`timescale 1ns / 1ps
package igf_pkg;
    localparam int POS_W = 32;
    localparam int MIN_W = 31;
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1) + 1;
    localparam int SDEPTH_W = 6;
    localparam int SDEPTH_MAX = 63;
    localparam int DEP_W = CNT_W + 1;
    localparam int RES_MAX = 33;
    localparam int RES_W = $clog2(RES_MAX + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd2;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic is_entry;
        pos_t pos;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    typedef struct packed {
        pos_t x;
        pos_t y;
        logic skip;
        logic spans;
        logic covers;
        logic want_entry;
        logic want_exit;
        logic last_item;
    } cmd_t;

    typedef struct packed {
        pos_t gap_start;
        pos_t gap_end;
        logic [POS_W-1:0] length_total;
    } gap_t;

    typedef struct packed {
        gap_t gap;
        logic gap_valid;
        logic fully_covered;
        logic store_overflow;
        logic last_result;
    } result_t;

    // Exits sort before entries at the same position.
    function automatic logic key_le(point_t a, point_t b);
        logic lt;
        lt = $signed(a.pos) < $signed(b.pos);
        if (a.pos != b.pos) begin
            return lt;
        end
        return a.is_entry <= b.is_entry;
    endfunction
endpackage

// ===== rtl/igf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module igf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/igf_front.sv =====
// Front end: takes interval words and classifies them against the window.
`timescale 1ns / 1ps
module igf_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  igf_pkg::pos_t     enter_pos,
    input  igf_pkg::pos_t     exit_pos,
    input  logic              final_interval,
    input  igf_pkg::pos_t     win_a,
    input  igf_pkg::pos_t     win_b,
    input  logic              q_full,
    output logic              q_push,
    output igf_pkg::cmd_t     q_data
);
    igf_pkg::pos_t x;
    igf_pkg::pos_t y;

    always_comb begin
        if ($signed(enter_pos) > $signed(exit_pos)) begin
            x = exit_pos;
            y = enter_pos;
        end else begin
            x = enter_pos;
            y = exit_pos;
        end
        q_data.x = x;
        q_data.y = y;
        q_data.skip = ($signed(y) <= $signed(win_a)) || (x == y);
        q_data.spans = $signed(x) < $signed(win_a);
        q_data.covers = ($signed(x) < $signed(win_a)) && ($signed(y) > $signed(win_b));
        q_data.want_entry = ($signed(x) >= $signed(win_a)) && ($signed(x) <= $signed(win_b));
        q_data.want_exit = $signed(y) <= $signed(win_b);
        q_data.last_item = final_interval;
    end

    assign s_tready = !q_full;
    assign q_push = s_tvalid && !q_full;
endmodule

// ===== rtl/igf_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module igf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  igf_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output igf_pkg::cmd_t pop_data,
    output logic          pop_valid
);
    igf_pkg::cmd_t entry_reg [2];
    logic wptr_reg;
    logic rptr_reg;
    logic [1:0] fill_reg;

    assign full = fill_reg[1];
    assign pop_valid = fill_reg != 2'd0;
    assign pop_data = entry_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push) begin
                entry_reg[wptr_reg] <= push_data;
                wptr_reg <= !wptr_reg;
            end
            if (pop) begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/igf_back.sv =====
// Back end: sorted insertion into the point store and the gap sweep.
`timescale 1ns / 1ps
module igf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  igf_pkg::cmd_t                 q_data,
    output logic                          q_pop,
    input  igf_pkg::pos_t                 win_a,
    input  igf_pkg::pos_t                 win_b,
    input  logic [igf_pkg::MIN_W-1:0]     min_len,
    output logic                          m_valid,
    input  logic                          m_ready,
    output igf_pkg::result_t              m_result,
    output logic [igf_pkg::CNT_W-1:0]     point_count
);
    typedef enum logic [2:0] {
        B_IDLE, B_ACCEPT, B_INS_RD, B_INS_CMP, B_SW_RD, B_SW_PROC, B_SW_TAIL, B_SW_FIN
    } state_t;

    state_t state_reg, state_next;
    igf_pkg::cmd_t cmd_reg, cmd_next;
    logic [igf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [igf_pkg::SDEPTH_W-1:0] sdepth_reg, sdepth_next;
    logic cov_reg, cov_next, ovf_reg, ovf_next;
    logic [igf_pkg::CNT_W-1:0] idx_reg, idx_next;
    igf_pkg::point_t key_reg, key_next;
    logic exit_pend_reg, exit_pend_next;
    logic [igf_pkg::DEP_W-1:0] depth_reg, depth_next;
    igf_pkg::pos_t seg_reg, seg_next;
    logic [igf_pkg::CNT_W-1:0] j_reg, j_next;
    logic [igf_pkg::POS_W-1:0] total_reg, total_next;
    logic [igf_pkg::RES_W-1:0] n_reg, n_next;
    igf_pkg::gap_t pend_reg, pend_next;
    logic have_pend_reg, have_pend_next;
    logic m_valid_reg, m_valid_next;
    igf_pkg::result_t out_reg, out_next;

    logic we, re;
    logic [igf_pkg::ADDR_W-1:0] waddr, raddr;
    igf_pkg::point_t wdata, rd;
    logic [igf_pkg::POINT_W-1:0] rdata_raw;

    logic [igf_pkg::CNT_W-1:0] need;
    igf_pkg::pos_t cand_pos;
    logic [igf_pkg::POS_W:0] len;
    logic gap_ok, out_free, produce, stall;
    igf_pkg::gap_t new_gap;

    igf_ram #(.WIDTH(igf_pkg::POINT_W), .DEPTH(igf_pkg::MAX_POINTS)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rdata_raw)
    );
    assign rd = igf_pkg::point_t'(rdata_raw);

    assign cand_pos = (state_reg == B_SW_TAIL) ? win_b : rd.pos;
    assign len = {cand_pos[igf_pkg::POS_W-1], cand_pos} - {seg_reg[igf_pkg::POS_W-1], seg_reg};
    assign gap_ok = !len[igf_pkg::POS_W] && (len != '0)
        && (len > {2'b00, min_len}) && (n_reg < igf_pkg::RES_W'(igf_pkg::RES_MAX));
    assign new_gap = '{gap_start: seg_reg, gap_end: cand_pos,
                       length_total: total_reg + len[igf_pkg::POS_W-1:0]};
    assign out_free = !m_valid_reg || m_ready;
    assign need = igf_pkg::CNT_W'(cmd_reg.want_entry) + igf_pkg::CNT_W'(cmd_reg.want_exit);

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        cnt_next = cnt_reg;
        sdepth_next = sdepth_reg;
        cov_next = cov_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        key_next = key_reg;
        exit_pend_next = exit_pend_reg;
        depth_next = depth_reg;
        seg_next = seg_reg;
        j_next = j_reg;
        total_next = total_reg;
        n_next = n_reg;
        pend_next = pend_reg;
        have_pend_next = have_pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next = out_reg;
        q_pop = 1'b0;
        we = 1'b0;
        re = 1'b0;
        waddr = idx_reg[igf_pkg::ADDR_W-1:0];
        wdata = key_reg;
        raddr = '0;
        produce = 1'b0;
        stall = 1'b0;

        unique case (state_reg) inside
            B_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    cmd_next = q_data;
                    state_next = B_ACCEPT;
                end
            end
            B_ACCEPT: begin
                state_next = cmd_reg.last_item ? B_SW_RD : B_IDLE;
                if (!cmd_reg.skip) begin
                    if (cnt_reg + need > igf_pkg::CNT_W'(igf_pkg::MAX_POINTS)) begin
                        ovf_next = 1'b1;
                    end else begin
                        if (cmd_reg.spans) begin
                            if (sdepth_reg < igf_pkg::SDEPTH_W'(igf_pkg::SDEPTH_MAX)) begin
                                sdepth_next = sdepth_reg + 1'b1;
                            end
                            cov_next = cov_reg | cmd_reg.covers;
                        end
                        idx_next = cnt_reg;
                        if (cmd_reg.want_entry) begin
                            key_next = '{is_entry: 1'b1, pos: cmd_reg.x};
                            exit_pend_next = cmd_reg.want_exit;
                            state_next = B_INS_RD;
                        end else if (cmd_reg.want_exit) begin
                            key_next = '{is_entry: 1'b0, pos: cmd_reg.y};
                            exit_pend_next = 1'b0;
                            state_next = B_INS_RD;
                        end
                    end
                end
            end
            B_INS_RD, B_INS_CMP: begin
                if (state_reg == B_INS_RD && idx_reg != '0) begin
                    re = 1'b1;
                    raddr = igf_pkg::ADDR_W'(idx_reg - 1'b1);
                    state_next = B_INS_CMP;
                end else if (state_reg == B_INS_CMP && !igf_pkg::key_le(rd, key_reg)) begin
                    we = 1'b1;
                    wdata = rd;
                    idx_next = idx_reg - 1'b1;
                    state_next = B_INS_RD;
                end else begin
                    we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (exit_pend_reg) begin
                        key_next = '{is_entry: 1'b0, pos: cmd_reg.y};
                        idx_next = cnt_reg + 1'b1;
                        exit_pend_next = 1'b0;
                        state_next = B_INS_RD;
                    end else begin
                        state_next = cmd_reg.last_item ? B_SW_RD : B_IDLE;
                    end
                end
            end
            B_SW_RD: begin
                if (j_reg == cnt_reg) begin
                    state_next = B_SW_TAIL;
                end else begin
                    re = 1'b1;
                    raddr = j_reg[igf_pkg::ADDR_W-1:0];
                    state_next = B_SW_PROC;
                end
            end
            B_SW_PROC: begin
                if (rd.is_entry) begin
                    produce = (depth_reg == '0) && gap_ok;
                    stall = produce && have_pend_reg && !out_free;
                    if (!stall) begin
                        depth_next = depth_reg + 1'b1;
                    end
                end else if (depth_reg != '0) begin
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == igf_pkg::DEP_W'(1)) begin
                        seg_next = rd.pos;
                    end
                end
                if (!stall) begin
                    j_next = j_reg + 1'b1;
                    state_next = B_SW_RD;
                end
            end
            B_SW_TAIL: begin
                produce = (depth_reg == '0) && gap_ok;
                stall = produce && have_pend_reg && !out_free;
                if (!stall) begin
                    state_next = B_SW_FIN;
                end
            end
            B_SW_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_next.gap = have_pend_reg ? pend_reg : '0;
                    out_next.gap_valid = have_pend_reg;
                    out_next.fully_covered = cov_reg;
                    out_next.store_overflow = ovf_reg;
                    out_next.last_result = 1'b1;
                    cnt_next = '0;
                    sdepth_next = '0;
                    cov_next = 1'b0;
                    ovf_next = 1'b0;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        if (produce && !stall) begin
            if (have_pend_reg) begin
                m_valid_next = 1'b1;
                out_next.gap = pend_reg;
                out_next.gap_valid = 1'b1;
                out_next.fully_covered = cov_reg;
                out_next.store_overflow = ovf_reg;
                out_next.last_result = 1'b0;
            end
            pend_next = new_gap;
            have_pend_next = 1'b1;
            total_next = new_gap.length_total;
            n_next = n_reg + 1'b1;
        end

        // Sweep setup whenever the sweep is entered.
        if (state_next == B_SW_RD && state_reg != B_SW_RD && state_reg != B_SW_PROC) begin
            depth_next = igf_pkg::DEP_W'(sdepth_next);
            seg_next = win_a;
            j_next = '0;
            total_next = '0;
            n_next = '0;
            have_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            cnt_reg <= '0;
            sdepth_reg <= '0;
            cov_reg <= 1'b0;
            ovf_reg <= 1'b0;
            exit_pend_reg <= 1'b0;
            have_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sdepth_reg <= sdepth_next;
            cov_reg <= cov_next;
            ovf_reg <= ovf_next;
            exit_pend_reg <= exit_pend_next;
            have_pend_reg <= have_pend_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        key_reg <= key_next;
        depth_reg <= depth_next;
        seg_reg <= seg_next;
        j_reg <= j_next;
        total_reg <= total_next;
        n_reg <= n_next;
        pend_reg <= pend_next;
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_result = out_reg;
    assign point_count = cnt_reg;
endmodule

// ===== rtl/interval_gap_finder_core.sv =====
// Interval gap finder: window registers, front end, queue and back end.
// An item is classified combinationally and queued; the back end pops it in B_IDLE and takes
// it in B_ACCEPT, then shifts each larger stored point up through B_INS_RD and B_INS_CMP
// before writing the new point. After the last interval the sweep reads each stored point
// through B_SW_RD and B_SW_PROC, then B_SW_TAIL and B_SW_FIN; the back end takes no new item
// while it inserts or sweeps, so throughput is set by the sorted store.
// aresetn is synchronous and active low; it clears counts, flags and handshakes,
// loads the window registers with their defaults and leaves the store unwritten.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module interval_gap_finder_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // enter_pos [31:0], exit_pos [63:32]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // gap_start [31:0], gap_end [63:32], length_total [95:64],
    // fully_covered [96], store_overflow [97], zero [103:98]
    output logic [103:0] m_tdata,
    output logic         m_tuser,   // gap_valid [0]
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [igf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);
    igf_pkg::pos_t wstart_reg, wend_reg, win_b;
    logic [igf_pkg::MIN_W-1:0] min_len_reg;
    logic q_full, q_push, q_pop, q_valid;
    igf_pkg::cmd_t push_cmd, pop_cmd;
    igf_pkg::result_t res;
    logic [igf_pkg::CNT_W-1:0] point_count;

    assign cfg_ready = 1'b1;
    assign win_b = ($signed(wend_reg) < $signed(wstart_reg)) ? wstart_reg : wend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wstart_reg <= '0;
            wend_reg <= igf_pkg::pos_t'(65536);
            min_len_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                igf_pkg::CFG_WINDOW_START: wstart_reg <= cfg_data;
                igf_pkg::CFG_WINDOW_END: wend_reg <= cfg_data;
                igf_pkg::CFG_MIN_LEN: min_len_reg <= cfg_data[igf_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    igf_front u_front (
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .enter_pos(s_tdata[31:0]), .exit_pos(s_tdata[63:32]), .final_interval(s_tlast),
        .win_a(wstart_reg), .win_b(win_b), .q_full(q_full), .q_push(q_push), .q_data(push_cmd)
    );

    igf_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_data(push_cmd), .full(q_full),
        .pop(q_pop), .pop_data(pop_cmd), .pop_valid(q_valid)
    );

    igf_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_data(pop_cmd), .q_pop(q_pop),
        .win_a(wstart_reg), .win_b(win_b), .min_len(min_len_reg),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_result(res), .point_count(point_count)
    );

    assign m_tdata = {6'b0, res.store_overflow, res.fully_covered, res.gap.length_total,
                      res.gap.gap_end, res.gap.gap_start};
    assign m_tuser = res.gap_valid;
    assign m_tlast = res.last_result;

    `ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1,
        point_count <= igf_pkg::CNT_W'(igf_pkg::MAX_POINTS))
    `ASSERT_IMPLIES(a_summary_last, aclk, aresetn, m_tvalid && !m_tuser, m_tlast)
    `ASSERT_IMPLIES(a_summary_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[95:0] == 96'd0)
endmodule

// ===== tb/tb_interval_gap_finder_core.sv =====
// Self-checking testbench for the interval gap finder core.
`timescale 1ns / 1ps
module tb_interval_gap_finder_core;

    typedef struct {
        logic [31:0] gap_start;
        logic [31:0] gap_end;
        logic        gap_valid;
        logic [31:0] length_total;
        logic        fully_covered;
        logic        store_overflow;
        logic        last_result;
    } gap_word_t;

    typedef struct {
        logic signed [31:0] pos;
        logic               is_entry;
    } mark_t;

    typedef struct {
        logic [31:0] enter_pos;
        logic [31:0] exit_pos;
        logic        final_interval;
        logic        typed;
        gap_word_t   want;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [igf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]  cfg_data;

    interval_gap_finder_core DUT (.*);

    gap_word_t   gaps_pending[$];
    mark_t       marks[$];
    logic [31:0] win_start, win_end;
    logic [30:0] gap_floor;
    int          open_depth;
    logic        spans_all, dropped;
    int          errors;
    int          idle_count;
    int          quiet_pct;
    int          stall_pct;
    bit          done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task automatic sweep_reset();
        marks.delete();
        open_depth = 0;
        spans_all = 1'b0;
        dropped = 1'b0;
    endtask

    function automatic gap_word_t make_gap(logic [31:0] gs, logic [31:0] ge, logic v,
                                           logic [31:0] tot);
        gap_word_t g;
        g.gap_start = gs;
        g.gap_end = ge;
        g.gap_valid = v;
        g.length_total = tot;
        g.fully_covered = spans_all;
        g.store_overflow = dropped;
        g.last_result = 1'b0;
        return g;
    endfunction

    function automatic bit same_word(gap_word_t a, gap_word_t b);
        return a.gap_start === b.gap_start && a.gap_end === b.gap_end
            && a.gap_valid === b.gap_valid && a.length_total === b.length_total
            && a.fully_covered === b.fully_covered && a.store_overflow === b.store_overflow
            && a.last_result === b.last_result;
    endfunction

    task automatic queue_word(gap_word_t g);
        gaps_pending.insert(gaps_pending.size(), g);
    endtask

    task automatic mark_insert(logic signed [31:0] p, logic ent);
        int i;
        i = marks.size();
        while (i > 0 && (marks[i-1].pos > p || (marks[i-1].pos == p
               && marks[i-1].is_entry > ent)))
            i--;
        marks.insert(i, '{p, ent});
    endtask

    // Records one accepted interval and, on the final one, computes the gaps of the set and queues them.
    task automatic predict_gaps(logic [31:0] ep, logic [31:0] xp, logic fin, output int made);
        longint a, b, x, y, seg, len, total;
        int need, depth, n;
        a = longint'($signed(win_start));
        b = longint'($signed(win_end));
        if (b < a) b = a;
        x = longint'($signed(ep));
        y = longint'($signed(xp));
        if (x > y) begin
            seg = x; x = y; y = seg;
        end
        made = 0;
        if (!(y <= a || x == y)) begin
            need = ((x >= a && x <= b) ? 1 : 0) + ((y <= b) ? 1 : 0);
            if (marks.size() + need > igf_pkg::MAX_POINTS) begin
                dropped = 1'b1;
            end else begin
                if (x < a) begin
                    if (open_depth < igf_pkg::SDEPTH_MAX) open_depth++;
                    if (y > b) spans_all = 1'b1;
                end
                if (x >= a && x <= b) mark_insert(x[31:0], 1'b1);
                if (y <= b) mark_insert(y[31:0], 1'b0);
            end
        end
        if (!fin) return;
        depth = open_depth;
        seg = a;
        total = 0;
        n = 0;
        foreach (marks[i]) begin
            if (marks[i].is_entry) begin
                depth++;
                if (depth == 1) begin
                    len = longint'(marks[i].pos) - seg;
                    if (len > 0 && len > longint'(gap_floor) && n < igf_pkg::RES_MAX) begin
                        total += len;
                        queue_word(make_gap(seg[31:0], marks[i].pos, 1'b1, total[31:0]));
                        n++;
                    end
                end
            end else if (depth > 0) begin
                depth--;
                if (depth == 0) seg = longint'(marks[i].pos);
            end
        end
        if (depth == 0) begin
            len = b - seg;
            if (len > 0 && len > longint'(gap_floor) && n < igf_pkg::RES_MAX) begin
                total += len;
                queue_word(make_gap(seg[31:0], b[31:0], 1'b1, total[31:0]));
                n++;
            end
        end
        if (n == 0) begin
            queue_word(make_gap(32'd0, 32'd0, 1'b0, 32'd0));
            n = 1;
        end
        gaps_pending[$].last_result = 1'b1;
        made = n;
        sweep_reset();
    endtask

    task automatic write_reg(logic [igf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            igf_pkg::CFG_WINDOW_START: win_start = val;
            igf_pkg::CFG_WINDOW_END: win_end = val;
            igf_pkg::CFG_MIN_LEN: gap_floor = val[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (gaps_pending.size() > 0) @(posedge aclk);
    endtask

    task automatic drain();
        settle();
        repeat (300) @(posedge aclk);
    endtask

    task automatic send(logic [31:0] ep, logic [31:0] xp, logic fin);
        int made;
        while ($urandom_range(99) < quiet_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {xp, ep};
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_gaps(ep, xp, fin, made);
    endtask

    function automatic logic [31:0] rand_pos(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(70000);
            default: return 32'($signed($urandom_range(140000)) - 70000);
        endcase
    endfunction

    // Receiver with random stalls and checker.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                gap_word_t got;
                got.gap_start = m_tdata[31:0];
                got.gap_end = m_tdata[63:32];
                got.length_total = m_tdata[95:64];
                got.fully_covered = m_tdata[96];
                got.store_overflow = m_tdata[97];
                got.gap_valid = m_tuser;
                got.last_result = m_tlast;
                if (gaps_pending.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    gap_word_t w;
                    w = gaps_pending.pop_front();
                    if (got.gap_start !== w.gap_start)
                        report($sformatf("gap_start %h want %h", got.gap_start, w.gap_start));
                    if (got.gap_end !== w.gap_end)
                        report($sformatf("gap_end %h want %h", got.gap_end, w.gap_end));
                    if (got.gap_valid !== w.gap_valid) report("gap_valid");
                    if (got.length_total !== w.length_total)
                        report($sformatf("length_total %h want %h", got.length_total,
                                         w.length_total));
                    if (got.fully_covered !== w.fully_covered) report("fully_covered");
                    if (got.store_overflow !== w.store_overflow) report("store_overflow");
                    if (got.last_result !== w.last_result) report("last_result");
                    if (m_tdata[103:98] !== 6'd0) report("padding bits");
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || done)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > 20000) begin
            $display("[interval_gap_finder_core] ERROR");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        row_t r;
        int n;
        int len;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = igf_pkg::CFG_WINDOW_START;
        cfg_data = '0;
        errors = 0;
        idle_count = 0;
        done = 1'b0;
        quiet_pct = 10;
        stall_pct = 10;
        win_start = 32'd0;
        win_end = 32'd65536;
        gap_floor = '0;
        sweep_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows with default window [0, 1.0].
        rows.insert(rows.size(), '{32'd0, 32'd0, 1'b1, 1'b1,
                    '{32'd0, 32'd65536, 1'b1, 32'd65536, 1'b0, 1'b0, 1'b1}});
        rows.insert(rows.size(), '{32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1,
                    '{32'd0, 32'd0, 1'b0, 32'd0, 1'b1, 1'b0, 1'b1}});
        rows.insert(rows.size(), '{32'd0, 32'hffff_0000, 1'b1, 1'b1,
                    '{32'd0, 32'd65536, 1'b1, 32'd65536, 1'b0, 1'b0, 1'b1}});
        rows.insert(rows.size(), '{32'd40000, 32'd20000, 1'b0, 1'b0, '{default: '0}});
        rows.insert(rows.size(), '{32'd30000, 32'd30000, 1'b0, 1'b0, '{default: '0}});
        rows.insert(rows.size(), '{32'd20000, 32'd30000, 1'b0, 1'b0, '{default: '0}});
        rows.insert(rows.size(), '{32'd30000, 32'd50000, 1'b0, 1'b0, '{default: '0}});
        rows.insert(rows.size(), '{32'hffff_0000, 32'd10000, 1'b0, 1'b0, '{default: '0}});
        rows.insert(rows.size(), '{32'd60000, 32'd90000, 1'b1, 1'b0, '{default: '0}});
        rows.insert(rows.size(), '{32'd65536, 32'd65540, 1'b1, 1'b0, '{default: '0}});
        foreach (rows[i]) begin
            r = rows[i];
            if (r.typed) begin
                send(r.enter_pos, r.exit_pos, r.final_interval);
                if (!same_word(gaps_pending[$], r.want)) report("directed row table entry");
            end else begin
                send(r.enter_pos, r.exit_pos, r.final_interval);
            end
        end
        drain();

        // Overflow: fill the store with more points than it holds.
        for (int i = 0; i < 34; i++) send(32'(1000 * i + 100), 32'(1000 * i + 600), 1'b0);
        send(32'd50000, 32'd50010, 1'b1);
        drain();

        // Reversed window, extreme window and a minimum length setting.
        write_reg(igf_pkg::CFG_WINDOW_START, 32'd5000);
        write_reg(igf_pkg::CFG_WINDOW_END, 32'd1000);
        send(32'd0, 32'd6000, 1'b1);
        send(32'd3000, 32'd4000, 1'b1);
        drain();
        write_reg(igf_pkg::CFG_WINDOW_START, 32'h8000_0000);
        write_reg(igf_pkg::CFG_WINDOW_END, 32'h7fff_ffff);
        write_reg(igf_pkg::CFG_MIN_LEN, 32'h7fff_ffff);
        send(32'd0, 32'd1, 1'b1);
        drain();
        write_reg(igf_pkg::CFG_MIN_LEN, 32'd0);
        send(32'h8000_0000, 32'd0, 1'b0);
        send(32'd10, 32'h7fff_ffff, 1'b1);
        drain();

        // Random phases: each configures a window and sends short interval sets, with one longer set in phase 1.
        n = 0;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(igf_pkg::CFG_WINDOW_START, phase == 5 ? $urandom : 32'd0);
            write_reg(igf_pkg::CFG_WINDOW_END, phase == 5 ? $urandom : 32'd65536);
            write_reg(igf_pkg::CFG_MIN_LEN, phase == 3 ? 32'($urandom_range(20000)) :
                      (phase == 4 ? 32'h7fff_ffff & $urandom : 32'd0));
            quiet_pct = (phase == 2) ? 0 : 10;
            stall_pct = (phase == 2) ? 0 : 10;
            for (int s = 0; s < 8; s++) begin
                len = $urandom_range(1, (s == 7 && phase == 1) ? 40 : 6);
                for (int k = 0; k < len; k++) begin
                    send(rand_pos(phase == 5 ? 0 : $urandom_range(1, 2)),
                         rand_pos(phase == 5 ? 0 : $urandom_range(1, 2)), k == len - 1);
                    n++;
                end
            end
            // Let the block finish every set before the window changes.
            settle();
        end

        done = 1'b1;
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("[interval_gap_finder_core] OK");
        end else begin
            $display("[interval_gap_finder_core] ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/igf_pkg.sv
rtl/igf_ram.sv
rtl/igf_front.sv
rtl/igf_queue.sv
rtl/igf_back.sv
rtl/interval_gap_finder_core.sv
tb/tb_interval_gap_finder_core.sv
